/* hw/rtl/cyclic_turn_code_canonicalizer_unit_defines.svh */
// assertion macros shared by the turn code canonicaliser rtl
`ifndef CYCLIC_TURN_CODE_CANONICALIZER_UNIT_DEFINES_SVH
`define CYCLIC_TURN_CODE_CANONICALIZER_UNIT_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define CTCC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ctcc check failed");

// next-cycle implication, checked on every rising clock edge outside reset
`define CTCC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ctcc check failed");

`endif

/* hw/rtl/ctcc_pkg.sv */
// shared types, constants and helper functions of the turn code canonicaliser
package ctcc_pkg;

   localparam int MAX_SEGMENTS = 63;
   localparam int MIN_SEGMENTS = 6;
   localparam int CODE_W       = 63;
   localparam int LEN_W        = 6;
   localparam int CNT_W        = 6;
   // doubled code word, wide enough for every rotation window
   localparam int DD_W         = 2 * CODE_W - 1;
   // leaves of the minimum tree and its pipeline stages
   localparam int LEAVES       = 64;
   localparam int TREE_DEPTH   = 6;
   localparam int STAGES       = 4 + TREE_DEPTH;

   typedef logic [CODE_W-1:0] code_type;
   typedef logic [LEN_W-1:0]  len_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [DD_W-1:0]   dd_type;

   // clamp the written segment count into the supported range
   function automatic len_type clamp_len(input len_type raw);
      len_type res;
      res = raw;
      if (raw < len_type'(MIN_SEGMENTS)) res = len_type'(MIN_SEGMENTS);
      if (raw > len_type'(MAX_SEGMENTS)) res = len_type'(MAX_SEGMENTS);
      return res;
   endfunction

   // full-width bit order reversal
   function automatic code_type reverse_code(input code_type c);
      code_type r;
      for (int k = 0; k < CODE_W; k++) begin
         r[CODE_W-1-k] = c[k];
      end
      return r;
   endfunction

   function automatic code_type min_code(input code_type a, input code_type b);
      return (a < b) ? a : b;
   endfunction

endpackage

/* hw/rtl/ctcc_if.sv */
// handshake channels of the turn code canonicaliser: request, result and register write
interface ctcc_req_if import ctcc_pkg::*; ();
   logic     valid;
   logic     ready;
   code_type polygon_code;

   modport source (output valid, output polygon_code, input ready);
   modport sink   (input valid, input polygon_code, output ready);
endinterface

interface ctcc_rsp_if import ctcc_pkg::*; ();
   logic     valid;
   logic     ready;
   code_type primitive_code;
   cnt_type  rotation_matches;
   logic     mirror_symmetric;

   modport source (output valid, output primitive_code, output rotation_matches,
                   output mirror_symmetric, input ready);
   modport sink   (input valid, input primitive_code, input rotation_matches,
                   input mirror_symmetric, output ready);
endinterface

interface ctcc_csr_if import ctcc_pkg::*; ();
   logic    valid;
   logic    ready;
   len_type segment_count;

   modport source (output valid, output segment_count, input ready);
   modport sink   (input valid, input segment_count, output ready);
endinterface

/* hw/rtl/cyclic_turn_code_canonicalizer_unit.sv */
// Canonicaliser for closed polygon turn codes of N bits (N = segment count, clamped to
// 6..63, reset 6). Each request beat returns one result beat: the smallest of all N
// rotations of the code and of its inverted reversal, how many rotations reproduce the
// code, and whether the plain reversal is a rotation of the code. Input bits at N and
// above are ignored. The pipeline has ten register stages; one request beat is taken
// every cycle unless a held result beat has stalled the pipeline back to its first
// stage. Four stages mask, reverse, double and compare the code across all rotation
// lanes; the remaining six are the registered minimum tree over 64 leaves, whose depth
// sets the latency. Stages hand on only where the next one is empty or moving, so a held
// result beat stalls just as far back as the pipeline is full. The user must write the
// segment count register only while no beat is in flight; the block itself does not
// enforce this. Its write channel is always ready.
`include "cyclic_turn_code_canonicalizer_unit_defines.svh"

module cyclic_turn_code_canonicalizer_unit import ctcc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   ctcc_req_if.sink   req,
   ctcc_rsp_if.source rsp,
   ctcc_csr_if.sink   csr
);

   // configuration: clamped length and its mask
   len_type  len_ff, len_in;
   code_type mask_ff, mask_in;

   // per-stage valid bits and move enables
   logic [STAGES:1] stage_valid_ff;
   logic [STAGES:1] stage_en;

   // stage 1 to stage 3 payload
   code_type code1_ff, code1_in;
   code_type code2_ff, rev2_ff, rvt2_ff;
   code_type rev2_in, rvt2_in;
   code_type code3_ff;
   dd_type   dda3_ff, ddb3_ff, ddm3_ff;
   dd_type   dda3_in, ddb3_in, ddm3_in;

   // stage 4 lane results and the minimum tree (heap order, node k feeds from 2k, 2k+1)
   code_type            heap_ff [1:2*LEAVES-1];
   code_type            leaf_in [LEAVES];
   logic [CODE_W-1:0]   eq4_ff, eq4_in;
   logic                mir4_in;

   // side band carried along the tree stages
   cnt_type cnt_ff [5:STAGES];
   logic    mir_ff [4:STAGES];

   // range terms for the checks
   logic len_ok;
   logic cnt_ok;

   // register write
   assign csr.ready = 1'b1;
   assign len_in    = clamp_len(csr.segment_count);
   assign mask_in   = ~({CODE_W{1'b1}} << len_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= len_type'(MIN_SEGMENTS);
         mask_ff <= ~({CODE_W{1'b1}} << MIN_SEGMENTS);
      end else if (csr.valid) begin
         len_ff  <= len_in;
         mask_ff <= mask_in;
      end
   end

   // stage move enables, last stage first
   always_comb begin
      stage_en[STAGES] = !stage_valid_ff[STAGES] || rsp.ready;
      for (int k = STAGES - 1; k >= 1; k--) begin
         stage_en[k] = !stage_valid_ff[k] || stage_en[k+1];
      end
   end

   assign req.ready = stage_en[1];

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else begin
         if (stage_en[1]) stage_valid_ff[1] <= req.valid;
         for (int k = 2; k <= STAGES; k++) begin
            if (stage_en[k]) stage_valid_ff[k] <= stage_valid_ff[k-1];
         end
      end
   end

   // stage 1: drop bits above the segment count
   assign code1_in = req.polygon_code & mask_ff;

   // stage 2: reversal within N bits and its inverted form
   assign rev2_in = reverse_code(code1_ff) >> (len_type'(CODE_W) - len_ff);
   assign rvt2_in = ~rev2_in & mask_ff;

   // stage 3: doubled words, every rotation is then a fixed window
   assign dda3_in = DD_W'(code2_ff) | (DD_W'(code2_ff) << len_ff);
   assign ddb3_in = DD_W'(rvt2_ff)  | (DD_W'(rvt2_ff)  << len_ff);
   assign ddm3_in = DD_W'(rev2_ff)  | (DD_W'(rev2_ff)  << len_ff);

   // stage 4: one lane per rotation, compare and first minimum level
   always_comb begin
      code_type rot_a;
      code_type rot_b;
      code_type rot_m;
      logic     lane_on;
      mir4_in = 1'b0;
      eq4_in  = '0;
      for (int i = 0; i < LEAVES; i++) begin
         leaf_in[i] = {CODE_W{1'b1}};
      end
      for (int i = 0; i < MAX_SEGMENTS; i++) begin
         lane_on = (len_type'(i) < len_ff);
         rot_a   = dda3_ff[i +: CODE_W] & mask_ff;
         rot_b   = ddb3_ff[i +: CODE_W] & mask_ff;
         rot_m   = ddm3_ff[i +: CODE_W] & mask_ff;
         eq4_in[i] = lane_on && (rot_a == code3_ff);
         if (lane_on && (rot_m == code3_ff)) mir4_in = 1'b1;
         leaf_in[i] = lane_on ? min_code(rot_a, rot_b) : mask_ff;
      end
   end

   // front stage registers
   always_ff @(posedge clock) begin
      if (stage_en[1]) code1_ff <= code1_in;
      if (stage_en[2]) begin
         code2_ff <= code1_ff;
         rev2_ff  <= rev2_in;
         rvt2_ff  <= rvt2_in;
      end
      if (stage_en[3]) begin
         code3_ff <= code2_ff;
         dda3_ff  <= dda3_in;
         ddb3_ff  <= ddb3_in;
         ddm3_ff  <= ddm3_in;
      end
      if (stage_en[4]) begin
         eq4_ff <= eq4_in;
      end
   end

   // minimum tree: leaves loaded in stage 4, then one level per stage
   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         for (int i = 0; i < LEAVES; i++) begin
            heap_ff[LEAVES + i] <= leaf_in[i];
         end
      end
      for (int lvl = 0; lvl < TREE_DEPTH; lvl++) begin
         if (stage_en[STAGES - lvl]) begin
            for (int k = (1 << lvl); k < (2 << lvl); k++) begin
               heap_ff[k] <= min_code(heap_ff[2*k], heap_ff[2*k+1]);
            end
         end
      end
   end

   // mirror flag from stage 4, match count in stage 5, then both carried along
   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         mir_ff[4] <= mir4_in;
      end
      if (stage_en[5]) begin
         cnt_ff[5] <= cnt_type'($countones(eq4_ff));
         mir_ff[5] <= mir_ff[4];
      end
      for (int k = 6; k <= STAGES; k++) begin
         if (stage_en[k]) begin
            cnt_ff[k] <= cnt_ff[k-1];
            mir_ff[k] <= mir_ff[k-1];
         end
      end
   end

   // result beat
   assign rsp.valid            = stage_valid_ff[STAGES];
   assign rsp.primitive_code   = heap_ff[1];
   assign rsp.rotation_matches = cnt_ff[STAGES];
   assign rsp.mirror_symmetric = mir_ff[STAGES];

   // checks
   assign len_ok = (len_ff >= len_type'(MIN_SEGMENTS)) && (len_ff <= len_type'(MAX_SEGMENTS));
   assign cnt_ok = (cnt_ff[STAGES] != '0) && (cnt_ff[STAGES] <= len_ff);

   `CTCC_ASSERT_NOW(a_len_range, 1'b1, len_ok)
   `CTCC_ASSERT_NOW(a_match_range, stage_valid_ff[STAGES], cnt_ok)
   `CTCC_ASSERT_NOW(a_code_in_mask, stage_valid_ff[STAGES], (heap_ff[1] & ~mask_ff) == '0)
   `CTCC_ASSERT_NEXT(a_front_advance, stage_valid_ff[1] && stage_en[2], stage_valid_ff[2])

endmodule

/* test/tb_cyclic_turn_code_canonicalizer_unit.sv */
`timescale 1ns / 100ps
// self-checking bench for the turn code canonicaliser: table-driven and random beats
module tb_cyclic_turn_code_canonicalizer_unit import ctcc_pkg::*; ();

   // expected content of one result beat
   typedef struct packed {
      code_type primitive_code;
      cnt_type  rotation_matches;
      logic     mirror_symmetric;
   } canon_type;

   // one row of the directed table: segment count, code, and a typed-in answer if any
   typedef struct packed {
      len_type   seg;
      code_type  code;
      logic      typed;
      canon_type want;
   } stim_row_type;

   localparam int IDLE_LIMIT  = 4000;
   localparam int DRAIN_WAIT  = 20;
   localparam int RAND_PHASES = 9;
   localparam int PHASE_BEATS = 140;

   // idling per mode: receiver slower first, then sender slower, then neither
   localparam int SEND_PCT  [0:2] = '{30, 45, 0};
   localparam int STALL_PCT [0:2] = '{45, 30, 0};
   localparam len_type SEG_PLAN [0:7] = '{6'd63, 6'd0, 6'd17, 6'd6, 6'd32, 6'd63, 6'd45, 6'd9};

   localparam int DIR_ROWS = 22;
   localparam stim_row_type DIR_TABLE [0:DIR_ROWS-1] = '{
      // reset segment count of six, answers read straight off
      '{6'd6,  63'h0,                     1'b1, '{63'd0,  6'd6,  1'b1}},
      '{6'd6,  63'h7FFF_FFFF_FFFF_FFFF,   1'b1, '{63'd0,  6'd6,  1'b1}},
      '{6'd6,  63'h7FFF_FFFF_FFFF_FFC0,   1'b1, '{63'd0,  6'd6,  1'b1}},
      '{6'd6,  63'h1,                     1'b1, '{63'd1,  6'd1,  1'b1}},
      '{6'd6,  63'h2A,                    1'b1, '{63'd21, 6'd3,  1'b1}},
      '{6'd6,  63'h0B,                    1'b0, '0},
      // counts below six behave as six
      '{6'd0,  63'h3,                     1'b0, '0},
      '{6'd0,  63'h0,                     1'b1, '{63'd0,  6'd6,  1'b1}},
      '{6'd5,  63'h1234_5678_9ABC_DEF0,   1'b0, '0},
      // widest code
      '{6'd63, 63'h0,                     1'b1, '{63'd0,  6'd63, 1'b1}},
      '{6'd63, 63'h7FFF_FFFF_FFFF_FFFF,   1'b1, '{63'd0,  6'd63, 1'b1}},
      '{6'd63, 63'h1,                     1'b1, '{63'd1,  6'd1,  1'b1}},
      '{6'd63, 63'h4000_0000_0000_0000,   1'b1, '{63'd1,  6'd1,  1'b1}},
      '{6'd63, 63'h7FFF_FFFF_FFFF_FFFE,   1'b1, '{63'd1,  6'd1,  1'b1}},
      '{6'd63, 63'h5555_5555_5555_5555,   1'b0, '0},
      '{6'd63, 63'h2AAA_AAAA_AAAA_AAAA,   1'b0, '0},
      '{6'd63, 63'h0123_4567_89AB_CDEF,   1'b0, '0},
      // odd and mid sizes, junk above the code
      '{6'd7,  63'h55,                    1'b0, '0},
      '{6'd32, 63'h0000_0000_FFFF_0000,   1'b0, '0},
      '{6'd32, 63'h7FFF_FFFF_AAAA_AAAA,   1'b0, '0},
      '{6'd62, 63'h7FFF_FFFF_FFFF_FFFF,   1'b1, '{63'd0,  6'd62, 1'b1}},
      '{6'd62, 63'h1555_5555_5555_5555,   1'b0, '0}
   };

   logic clock;
   logic reset;

   ctcc_req_if req_ch ();
   ctcc_rsp_if rsp_ch ();
   ctcc_csr_if csr_ch ();

   cyclic_turn_code_canonicalizer_unit DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source),
      .csr   (csr_ch.sink)
   );

   canon_type pending_canon [$];
   len_type   seg_now = 6'd6;
   int        send_idle_pct = 0;
   int        stall_pct = 0;
   int        mismatches = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // effective code length for a written segment count
   function automatic int turn_len(input len_type seg);
      return (seg < len_type'(MIN_SEGMENTS)) ? MIN_SEGMENTS : int'(seg);
   endfunction

   // rotate right by one within n bits
   function automatic logic [63:0] rot1(input logic [63:0] x, input int n,
                                        input logic [63:0] mask);
      return ((x >> 1) | ((x & 64'd1) << (n - 1))) & mask;
   endfunction

   // canonical form, rotation count and mirror flag of one turn code
   function automatic canon_type canon_of_turn_code(input code_type raw_code,
                                                    input len_type seg);
      int          n;
      logic [63:0] mask, code, rev, reverted, best, a, b, m;
      cnt_type     hits;
      logic        mirr;
      canon_type   res;
      n = turn_len(seg);
      mask = (64'd1 << n) - 64'd1;
      code = {1'b0, raw_code} & mask;
      rev = '0;
      for (int k = 0; k < n; k++) begin
         if (code[k]) rev[n-1-k] = 1'b1;
      end
      reverted = ~rev & mask;
      best = mask;
      a = code;
      b = reverted;
      m = rev;
      hits = '0;
      mirr = 1'b0;
      for (int i = 0; i < n; i++) begin
         if (a < best) best = a;
         if (b < best) best = b;
         if (a == code) hits = hits + cnt_type'(1);
         if (m == code) mirr = 1'b1;
         a = rot1(a, n, mask);
         b = rot1(b, n, mask);
         m = rot1(m, n, mask);
      end
      res.primitive_code   = best[CODE_W-1:0];
      res.rotation_matches = hits;
      res.mirror_symmetric = mirr;
      return res;
   endfunction

   // random code, biased towards periodic, palindromic, sparse and dense shapes
   function automatic code_type gen_turn_code(input len_type seg);
      int          n, p, kind;
      code_type    c;
      logic [63:0] pat;
      n = turn_len(seg);
      kind = $urandom_range(0, 9);
      c = code_type'({$urandom, $urandom});
      case (kind)
         4, 5: begin
            p = $urandom_range(1, n);
            while (n % p != 0) p--;
            pat = {$urandom, $urandom};
            for (int k = 0; k < CODE_W; k++) c[k] = pat[k % p];
         end
         6: begin
            for (int k = 0; k < n / 2; k++) c[n-1-k] = c[k];
         end
         7: begin
            c = '0;
            repeat ($urandom_range(1, 3)) c[$urandom_range(0, CODE_W-1)] = 1'b1;
         end
         8: begin
            c = '1;
            repeat ($urandom_range(1, 3)) c[$urandom_range(0, CODE_W-1)] = 1'b0;
         end
         9: begin
            c = ($urandom_range(0, 1) == 0) ? '0 : '1;
         end
         default: ;
      endcase
      return c;
   endfunction

   // one line per mismatch, and count it
   task automatic note_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
      mismatches++;
   endtask

   // sender idles for a cycle at the chosen share before the next beat
   task automatic send_gap();
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // offer one code and record its answer once the beat is taken
   task automatic push_code(input code_type c, input logic typed, input canon_type given);
      req_ch.valid        <= 1'b1;
      req_ch.polygon_code <= c;
      do @(posedge clock); while (!req_ch.ready);
      pending_canon.push_back(typed ? given : canon_of_turn_code(c, seg_now));
   endtask

   // stop sending and wait for every outstanding result
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (pending_canon.size() != 0) @(posedge clock);
   endtask

   // write the segment count once the pipeline is empty
   task automatic write_segment_count(input len_type v);
      drain_results();
      csr_ch.valid         <= 1'b1;
      csr_ch.segment_count <= v;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      seg_now = v;
   endtask

   // result side: check each accepted beat, then pick next ready
   initial begin
      canon_type want;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_canon.size() == 0) begin
               note_mismatch("result beat with nothing outstanding",
                             64'(rsp_ch.primitive_code), '0);
            end else begin
               want = pending_canon.pop_front();
               if (rsp_ch.primitive_code !== want.primitive_code)
                  note_mismatch("primitive_code", 64'(rsp_ch.primitive_code),
                                64'(want.primitive_code));
               if (rsp_ch.rotation_matches !== want.rotation_matches)
                  note_mismatch("rotation_matches", 64'(rsp_ch.rotation_matches),
                                64'(want.rotation_matches));
               if (rsp_ch.mirror_symmetric !== want.mirror_symmetric)
                  note_mismatch("mirror_symmetric", 64'(rsp_ch.mirror_symmetric),
                                64'(want.mirror_symmetric));
            end
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // watchdog on cycles without any beat
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // stimulus
   initial begin
      int mode;
      req_ch.valid         <= 1'b0;
      req_ch.polygon_code  <= '0;
      csr_ch.valid         <= 1'b0;
      csr_ch.segment_count <= '0;
      reset <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, first rows on the reset segment count
      send_idle_pct = SEND_PCT[0];
      stall_pct     = STALL_PCT[0];
      for (int r = 0; r < DIR_ROWS; r++) begin
         if (DIR_TABLE[r].seg != seg_now) write_segment_count(DIR_TABLE[r].seg);
         send_gap();
         push_code(DIR_TABLE[r].code, DIR_TABLE[r].typed, DIR_TABLE[r].want);
      end

      // random phases, three segment counts per idling mode
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         mode = ph / 3;
         send_idle_pct = SEND_PCT[mode];
         stall_pct     = STALL_PCT[mode];
         if (ph < RAND_PHASES - 1)
            write_segment_count(SEG_PLAN[ph]);
         else
            write_segment_count(len_type'($urandom_range(0, 63)));
         for (int k = 0; k < PHASE_BEATS; k++) begin
            send_gap();
            push_code(gen_turn_code(seg_now), 1'b0, '0);
         end
      end

      // wait out the pipeline, then a few spare cycles for strays
      drain_results();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0 && pending_canon.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
